/* design/arx_pkg.sv */
// Shared types and constants of the ARX process model filter.
package arx_pkg;

    // Sample, coefficient and dead-time widths.
    localparam int SAMPLE_W  = 16;
    localparam int COEF_W    = 18;
    localparam int DT_W      = 5;
    localparam int CFG_IDX_W = 3;

    // Default length of the transport-delay line.
    localparam int MAX_DELAY_DEFAULT = 16;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_A1        = 3'd0,
        REG_A2        = 3'd1,
        REG_A3        = 3'd2,
        REG_B1        = 3'd3,
        REG_B2        = 3'd4,
        REG_B3        = 3'd5,
        REG_DEAD_TIME = 3'd6
    } cfg_reg_t;

    // The full set of model coefficients, signed Q2.15.
    typedef struct packed {
        logic signed [COEF_W-1:0] a1;
        logic signed [COEF_W-1:0] a2;
        logic signed [COEF_W-1:0] a3;
        logic signed [COEF_W-1:0] b1;
        logic signed [COEF_W-1:0] b2;
        logic signed [COEF_W-1:0] b3;
    } coef_set_t;

endpackage

/* design/arx_delay_line.sv */
// Transport-delay shift line with a selectable tap for the dead time.
module arx_delay_line #(
    parameter int MAX_DELAY = arx_pkg::MAX_DELAY_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                shift_en,
    input  logic signed [arx_pkg::SAMPLE_W-1:0] sample_in,
    input  logic        [arx_pkg::DT_W-1:0]     dead_time,
    output logic signed [arx_pkg::SAMPLE_W-1:0] delayed
);

    localparam int IDX_W = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;

    logic signed [arx_pkg::SAMPLE_W-1:0] store_reg [MAX_DELAY];
    logic                                dt_over;
    logic        [IDX_W-1:0]             tap_idx;

    // Shift the newest sample in at entry 0; the line is cleared at reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_DELAY; i++) begin
                store_reg[i] <= '0;
            end
        end else if (shift_en) begin
            store_reg[0] <= sample_in;
            for (int i = 1; i < MAX_DELAY; i++) begin
                store_reg[i] <= store_reg[i-1];
            end
        end
    end

    // Dead time beyond the line length is held at the last tap.
    always_comb begin
        dt_over = (32'(dead_time) > 32'(MAX_DELAY));
        tap_idx = dt_over ? IDX_W'(MAX_DELAY - 1) : IDX_W'(32'(dead_time) - 32'd1);
    end

    // With no dead time the current sample passes straight through.
    assign delayed = (dead_time == '0) ? sample_in : store_reg[tap_idx];

endmodule

/* design/arx_core.sv */
// ARX difference equation: histories, six products, rounding and saturation.
module arx_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                step_en,
    input  logic signed [arx_pkg::SAMPLE_W-1:0] u_new,
    input  arx_pkg::coef_set_t                  coef,
    output logic signed [arx_pkg::SAMPLE_W-1:0] y_out,
    output logic                                y_sat
);

    localparam int PROD_W = arx_pkg::SAMPLE_W + arx_pkg::COEF_W;
    localparam int ACC_W  = PROD_W + 3;
    localparam int FRAC_SHIFT = 15;
    localparam int SH_W   = ACC_W - FRAC_SHIFT;

    logic signed [arx_pkg::SAMPLE_W-1:0] ih1_reg, ih2_reg;
    logic signed [arx_pkg::SAMPLE_W-1:0] oh0_reg, oh1_reg, oh2_reg;

    logic signed [PROD_W-1:0] p_b1, p_b2, p_b3, p_a1, p_a2, p_a3;
    logic signed [ACC_W-1:0]  acc;
    logic signed [ACC_W-1:0]  rounded;
    logic        [SH_W-1:0]   shifted;
    logic                     over;

    // Six independent products of Q3.12 samples and Q2.15 coefficients.
    always_comb begin
        p_b1 = coef.b1 * u_new;
        p_b2 = coef.b2 * ih1_reg;
        p_b3 = coef.b3 * ih2_reg;
        p_a1 = coef.a1 * oh0_reg;
        p_a2 = coef.a2 * oh1_reg;
        p_a3 = coef.a3 * oh2_reg;
    end

    // Exact sum, round half up and arithmetic shift down to Q3.12.
    always_comb begin
        acc = ACC_W'(p_b1) + ACC_W'(p_b2) + ACC_W'(p_b3)
            - ACC_W'(p_a1) - ACC_W'(p_a2) - ACC_W'(p_a3);
        rounded = acc + ACC_W'(1 <<< (FRAC_SHIFT - 1));
        shifted = rounded[ACC_W-1:FRAC_SHIFT];
    end

    // Clamp to the 16-bit range when the upper bits disagree with the sign.
    always_comb begin
        over = !((&shifted[SH_W-1:arx_pkg::SAMPLE_W-1])
              || (~|shifted[SH_W-1:arx_pkg::SAMPLE_W-1]));
        if (over) begin
            y_out = shifted[SH_W-1] ? {1'b1, {(arx_pkg::SAMPLE_W-1){1'b0}}}
                                    : {1'b0, {(arx_pkg::SAMPLE_W-1){1'b1}}};
        end else begin
            y_out = shifted[arx_pkg::SAMPLE_W-1:0];
        end
        y_sat = over;
    end

    // Advance the input and output histories once per item.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ih1_reg <= '0;
            ih2_reg <= '0;
            oh0_reg <= '0;
            oh1_reg <= '0;
            oh2_reg <= '0;
        end else if (step_en) begin
            ih2_reg <= ih1_reg;
            ih1_reg <= u_new;
            oh2_reg <= oh1_reg;
            oh1_reg <= oh0_reg;
            oh0_reg <= y_out;
        end
    end

endmodule

/* design/arx_model_filter.sv */
// Top level of the third-order ARX process model with dead time.
// Items pass the input register, then the result register once it is free.
// Throughput: one item per cycle unless the result side stalls; the output
// feedback is combinational through the six multipliers, adder and saturation logic.
// Reset (aresetn low, synchronous) clears the coefficients, the dead time,
// the delay line, both histories and all valid flags.
module arx_model_filter #(
    parameter int MAX_DELAY = arx_pkg::MAX_DELAY_DEFAULT
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [arx_pkg::SAMPLE_W-1:0]  s_sample_in,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [arx_pkg::SAMPLE_W-1:0]  m_sample_out,
    output logic                                 m_saturated,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic        [arx_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic        [arx_pkg::COEF_W-1:0]    cfg_data
);

    arx_pkg::coef_set_t                  coef_reg;
    logic        [arx_pkg::DT_W-1:0]     dead_time_reg;

    logic                                in_valid_reg;
    logic signed [arx_pkg::SAMPLE_W-1:0] in_sample_reg;
    logic                                out_valid_reg;
    logic signed [arx_pkg::SAMPLE_W-1:0] out_sample_reg;
    logic                                out_sat_reg;

    logic                                step;
    logic signed [arx_pkg::SAMPLE_W-1:0] u_delayed;
    logic signed [arx_pkg::SAMPLE_W-1:0] y_calc;
    logic                                y_sat;

    // Configuration writes are always taken; unknown indexes are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg      <= '0;
            dead_time_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                arx_pkg::REG_A1:        coef_reg.a1   <= cfg_data;
                arx_pkg::REG_A2:        coef_reg.a2   <= cfg_data;
                arx_pkg::REG_A3:        coef_reg.a3   <= cfg_data;
                arx_pkg::REG_B1:        coef_reg.b1   <= cfg_data;
                arx_pkg::REG_B2:        coef_reg.b2   <= cfg_data;
                arx_pkg::REG_B3:        coef_reg.b3   <= cfg_data;
                arx_pkg::REG_DEAD_TIME: dead_time_reg <= cfg_data[arx_pkg::DT_W-1:0];
                default: ;
            endcase
        end
    end

    // The item in the input register is processed whenever the result
    // register is empty or being emptied.
    assign step    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || step;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_sample_reg <= s_sample_in;
        end
    end

    arx_delay_line #(
        .MAX_DELAY (MAX_DELAY)
    ) u_delay (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .shift_en  (step),
        .sample_in (in_sample_reg),
        .dead_time (dead_time_reg),
        .delayed   (u_delayed)
    );

    arx_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (step),
        .u_new   (u_delayed),
        .coef    (coef_reg),
        .y_out   (y_calc),
        .y_sat   (y_sat)
    );

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_sample_reg <= y_calc;
            out_sat_reg    <= y_sat;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_sample_out = out_sample_reg;
    assign m_saturated  = out_sat_reg;

endmodule

/* design/arx_checker.sv */
// Port-level checker for the ARX model filter, bound to the top level.
module arx_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_ready,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic signed [arx_pkg::SAMPLE_W-1:0] m_sample_out,
    input logic                                m_saturated,
    input logic                                cfg_ready
);

    // A stalled result item holds its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_sample_out) && $stable(m_saturated))
        else $error("stalled result item changed");

    // A clipped result sits at one of the two range limits.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_saturated |->
            (m_sample_out == 16'sh7fff) || (m_sample_out == -16'sh8000))
        else $error("saturated flag without a limit value");

    // The input side only stalls behind a stalled result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled while the result side is free");

    // Reset leaves no result pending and configuration open.
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid && cfg_ready)
        else $error("result valid or configuration blocked after reset");

endmodule

bind arx_model_filter arx_checker u_arx_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_sample_out (m_sample_out),
    .m_saturated  (m_saturated),
    .cfg_ready    (cfg_ready)
);
